// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the remap table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on i_clk, switched off while i_rst_n is low.
`define SRRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// The named condition must never be seen at a clock edge outside reset.
`define SRRT_NEVER(label, cond, msg) \
    `SRRT_ASSERT(label, !(cond), msg)

`endif

// ===== src/srrt_pkg.sv =====
// Package with the word types, commands and constants of the remap table.
`default_nettype none
package srrt_pkg;

    localparam int unsigned VAL_W = 48;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [VAL_W-1:0] src_start;
        logic [VAL_W-1:0] dest_start;
        logic [VAL_W-1:0] window_length;
        logic [VAL_W-1:0] lookup_value;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0] mapped_value;
        logic             hit;
        logic             table_full;
    } t_out_word;

    typedef struct packed {
        logic [VAL_W-1:0] src;
        logic [VAL_W-1:0] dest;
        logic [VAL_W-1:0] len;
    } t_window;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic [VAL_W-1:0] key;
        t_window          win;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } t_state;

endpackage
`default_nettype wire

// ===== src/srrt_cell.sv =====
// One cell of the window chain: holds one window, shifts on insert, matches on lookup.
`default_nettype none
module srrt_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_occ,
    input  wire logic                      i_prev_le,
    input  wire srrt_pkg::t_window         i_prev_win,
    input  wire logic                      i_next_le,
    input  wire srrt_pkg::t_cell_cmd       i_cmd,
    output logic                           o_le,
    output srrt_pkg::t_window              o_win,
    output logic                           o_hit,
    output logic [srrt_pkg::VAL_W-1:0]     o_mapped
);

    srrt_pkg::t_window               r_win;
    srrt_pkg::t_window               n_win;
    logic                            r_hit;
    logic                            n_hit;
    logic [srrt_pkg::VAL_W-1:0]      r_mapped;
    logic [srrt_pkg::VAL_W-1:0]      n_mapped;
    logic [srrt_pkg::VAL_W:0]        win_end;
    logic                            sel;

    assign o_le  = i_occ && (r_win.src <= i_cmd.key);
    assign o_win = r_win;

    // The occupied cells whose start is at or below the key form a prefix;
    // on a lookup the last of them is the one that decides.
    assign sel     = o_le && !i_next_le;
    assign win_end = {1'b0, r_win.src} + {1'b0, r_win.len};

    always_comb begin
        n_win = r_win;
        if (i_cmd.ins && !o_le) begin
            n_win = i_prev_le ? i_cmd.win : i_prev_win;
        end
        n_hit    = sel && ({1'b0, i_cmd.key} < win_end);
        n_mapped = n_hit ? (i_cmd.key + r_win.dest - r_win.src) : '0;
    end

    always_ff @(posedge i_clk) begin
        r_win    <= n_win;
        r_hit    <= n_hit;
        r_mapped <= n_mapped;
    end

    assign o_hit    = r_hit;
    assign o_mapped = r_mapped;

endmodule
`default_nettype wire

// ===== src/sorted_range_remap_table_top.sv =====
// Top level of the sorted range remap table: cell chain, control and output register.
//
//   Channel | Valid      | Ready       | Word
//   --------+------------+-------------+-------------------------------
//   input   | i_in_valid | o_in_ready  | i_in_word  (srrt_pkg::t_in_word)
//   output  | o_out_valid| i_out_ready | o_out_word (srrt_pkg::t_out_word)
//
// Every word goes through these steps before its result reaches the output register:
// in S_IDLE it is accepted and captured, in S_EXEC all cells compare against the key
// in parallel (and shift on an insert), and in S_REDUCE the per-cell lookup results
// are merged through an OR tree into the output register. One word is in flight at a
// time, so the next word is not accepted until the result has been loaded.
// Reset is synchronous and active low; it empties the table at once by
// clearing the window count. The window storage itself is not reset.
// A result waiting in the output register does not block the next word; the merge
// cycle stalls only while the register still holds a word that is not being taken.
`default_nettype none
module sorted_range_remap_table_top #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire srrt_pkg::t_in_word     i_in_word,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output srrt_pkg::t_out_word         o_out_word
);

    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    srrt_pkg::t_state               r_state;
    srrt_pkg::t_state               n_state;
    srrt_pkg::t_in_word             r_item;
    logic [CNT_W-1:0]               r_count;
    logic                           r_full;
    logic                           r_out_valid;
    srrt_pkg::t_out_word            r_out;
    srrt_pkg::t_out_word            n_out;
    logic                           load_out;
    logic                           is_full;
    srrt_pkg::t_cell_cmd            cell_cmd;

    logic                           cell_le     [TABLE_ENTRIES];
    srrt_pkg::t_window              cell_win    [TABLE_ENTRIES];
    logic                           cell_hit    [TABLE_ENTRIES];
    logic [srrt_pkg::VAL_W-1:0]     cell_mapped [TABLE_ENTRIES];
    logic                           prev_le     [TABLE_ENTRIES];
    srrt_pkg::t_window              prev_win    [TABLE_ENTRIES];
    logic                           next_le     [TABLE_ENTRIES];

    logic                           hit_any;
    logic [srrt_pkg::VAL_W-1:0]     mapped_any;

    assign is_full = (r_count == CNT_W'(TABLE_ENTRIES));

    // The command reaching the cells. The key is the new window's start on
    // an insert and the value to translate otherwise.
    always_comb begin
        cell_cmd.ins = (r_state == srrt_pkg::S_EXEC) &&
                       (r_item.action == srrt_pkg::ACT_INSERT) && !is_full;
        cell_cmd.key = (r_item.action == srrt_pkg::ACT_INSERT) ?
                       r_item.src_start : r_item.lookup_value;
        cell_cmd.win.src  = r_item.src_start;
        cell_cmd.win.dest = r_item.dest_start;
        cell_cmd.win.len  = r_item.window_length;
    end

    // Neighbor links. The first cell sees an imaginary left neighbor that
    // always keeps, so a new smallest window lands in it; the last cell sees
    // a right neighbor that never matches.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign prev_le[g]  = 1'b1;
            assign prev_win[g] = '0;
        end else begin : g_rest
            assign prev_le[g]  = cell_le[g-1];
            assign prev_win[g] = cell_win[g-1];
        end
        if (g == TABLE_ENTRIES - 1) begin : g_last
            assign next_le[g] = 1'b0;
        end else begin : g_inner
            assign next_le[g] = cell_le[g+1];
        end

        srrt_cell u_cell (
            .i_clk      (i_clk),
            .i_occ      (CNT_W'(g) < r_count),
            .i_prev_le  (prev_le[g]),
            .i_prev_win (prev_win[g]),
            .i_next_le  (next_le[g]),
            .i_cmd      (cell_cmd),
            .o_le       (cell_le[g]),
            .o_win      (cell_win[g]),
            .o_hit      (cell_hit[g]),
            .o_mapped   (cell_mapped[g])
        );
    end

    // At most one cell reports a hit, and the others hold zero, so an OR
    // merges the results.
    always_comb begin
        hit_any    = 1'b0;
        mapped_any = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_any    = hit_any | cell_hit[i];
            mapped_any = mapped_any | cell_mapped[i];
        end
    end

    always_comb begin
        n_out = '0;
        unique case (r_item.action)
            srrt_pkg::ACT_INSERT: begin
                n_out.table_full = r_full;
            end
            srrt_pkg::ACT_LOOKUP: begin
                n_out.hit          = hit_any;
                n_out.mapped_value = hit_any ? mapped_any : r_item.lookup_value;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            srrt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = srrt_pkg::S_EXEC;
                end
            end
            srrt_pkg::S_EXEC: begin
                n_state = srrt_pkg::S_REDUCE;
            end
            srrt_pkg::S_REDUCE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = srrt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srrt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srrt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == srrt_pkg::S_EXEC) begin
                if (cell_cmd.ins) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (r_item.action == srrt_pkg::ACT_CLEAR) begin
                    r_count <= '0;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in_word;
        end
        if (r_state == srrt_pkg::S_EXEC) begin
            r_full <= is_full;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

// ===== src/srrt_checker.sv =====
// Port checker for the remap table and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module srrt_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire srrt_pkg::t_out_word  o_out_word
);

    `SRRT_ASSERT(a_out_hold,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word),
        "output word changed while stalled")
    `SRRT_NEVER(a_hit_and_full,
        o_out_valid && o_out_word.hit && o_out_word.table_full,
        "hit and table_full both set")
    `SRRT_ASSERT(a_full_zero,
        o_out_valid && o_out_word.table_full |-> o_out_word.mapped_value == '0,
        "dropped insert carries a value")
    `SRRT_ASSERT(a_one_in_flight,
        i_in_valid && o_in_ready |=> !o_in_ready,
        "second word taken while one is in flight")

endmodule

bind sorted_range_remap_table_top srrt_checker u_srrt_checker (.*);
`default_nettype wire
